// ===== sv/xed_pkg.sv =====
// Package for the XML entity decoder: item types, status codes and character constants.
// No dependencies; imported by the channel interface users and the top level.
`default_nettype none
package xed_pkg;

	localparam int NAME_MAX_DEF = 8;
	localparam int CMP_LEN      = 4;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNREC = 2'd1,
		ST_UNTERM = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		status_t    status;
		logic       end_of_text;
	} out_item_t;

	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_QUOT  = 8'h22;
	localparam logic [7:0] CH_GT    = 8'h3e;
	localparam logic [7:0] CH_LT    = 8'h3c;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_M     = 8'h6d;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_O     = 8'h6f;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_Q     = 8'h71;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_G     = 8'h67;
	localparam logic [7:0] CH_L     = 8'h6c;

endpackage
`default_nettype wire

// ===== sv/xed_stream_if.sv =====
// Valid/ready stream channel carrying one word of a given payload type.
// Depends on nothing; payload types come from xed_pkg at the point of use.
`default_nettype none
interface xed_stream_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/xml_entity_decoder.sv =====
// Top level of the XML entity decoder: entity state, name match and result register.
// Depends on xed_pkg and xed_stream_if.
//
//  channel  | dir | payload     | word
//  in_ch    | in  | in_item_t   | one text byte, last flag
//  out_ch   | out | out_item_t  | decoded byte, valid, status, end of text
//
// One word is accepted per cycle; its result, if any, appears in the result
// register on the next cycle. The result register sets the rate: a held result
// stalls input only while out_ch is not ready.
// arst_n clears entity state and the result valid flag; the name buffer has no reset.
`default_nettype none
module xml_entity_decoder
	import xed_pkg::*;
#(
	parameter int NAME_MAX = NAME_MAX_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	xed_stream_if.sink     in_ch,
	xed_stream_if.source   out_ch
);

	localparam int LEN_W = $clog2(NAME_MAX + 2);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(NAME_MAX);

	logic                 inside_q;
	logic [7:0]           name_q [CMP_LEN];
	logic [LEN_W-1:0]     len_q;
	logic [7:0]           num_q;
	logic [1:0]           phase_q;
	logic                 neg_q;
	logic                 out_valid_q;
	out_item_t            out_q;

	logic       in_acc;
	logic [7:0] b;
	logic       last;
	logic       is_digit;
	logic       is_space;
	logic       numeric;
	logic [7:0] num_x10;
	logic       emit;
	out_item_t  res;

	logic             inside_d;
	logic [LEN_W-1:0] len_d;
	logic [7:0]       num_d;
	logic [1:0]       phase_d;
	logic             neg_d;

	assign in_acc      = in_ch.valid && in_ch.ready;
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign b           = in_ch.data.in_byte;
	assign last        = in_ch.data.in_last;
	assign is_digit    = b inside {[CH_ZERO:CH_NINE]};
	assign is_space    = b inside {CH_SPACE, [CH_TAB:CH_CR]};
	assign numeric     = (len_q >= LEN_W'(1)) && (len_q <= LEN_MAX) && (name_q[0] == CH_HASH);
	assign num_x10     = {num_q[4:0], 3'b000} + {num_q[6:0], 1'b0};

	always_comb begin
		inside_d = inside_q;
		len_d    = len_q;
		num_d    = num_q;
		phase_d  = phase_q;
		neg_d    = neg_q;
		emit     = 1'b0;
		res      = '{out_byte: 8'd0, byte_valid: 1'b0, status: ST_OK, end_of_text: last};
		if (!inside_q) begin
			if (b == CH_AMP) begin
				inside_d = 1'b1;
				len_d    = '0;
				num_d    = '0;
				phase_d  = 2'd0;
				neg_d    = 1'b0;
				if (last) begin
					res.status = ST_UNTERM;
				end
			end else begin
				res.out_byte   = b;
				res.byte_valid = 1'b1;
				emit           = 1'b1;
			end
		end else if (b == CH_SEMI) begin
			inside_d = 1'b0;
			emit     = 1'b1;
			res.byte_valid = 1'b1;
			if (numeric) begin
				res.out_byte = neg_q ? 8'(8'd0 - num_q) : num_q;
			end else if (len_q == LEN_W'(3) && name_q[0] == CH_A && name_q[1] == CH_M
					&& name_q[2] == CH_P) begin
				res.out_byte = CH_AMP;
			end else if (len_q == LEN_W'(4) && name_q[0] == CH_A && name_q[1] == CH_P
					&& name_q[2] == CH_O && name_q[3] == CH_S) begin
				res.out_byte = CH_APOS;
			end else if (len_q == LEN_W'(4) && name_q[0] == CH_Q && name_q[1] == CH_U
					&& name_q[2] == CH_O && name_q[3] == CH_T) begin
				res.out_byte = CH_QUOT;
			end else if (len_q == LEN_W'(2) && name_q[0] == CH_G && name_q[1] == CH_T) begin
				res.out_byte = CH_GT;
			end else if (len_q == LEN_W'(2) && name_q[0] == CH_L && name_q[1] == CH_T) begin
				res.out_byte = CH_LT;
			end else begin
				res.byte_valid = 1'b0;
				res.status     = ST_UNREC;
			end
		end else begin
			if (numeric) begin
				case (phase_q)
					2'd0: begin
						if (!is_space) begin
							if (b == CH_PLUS || b == CH_MINUS) begin
								neg_d   = (b == CH_MINUS);
								phase_d = 2'd1;
							end else if (is_digit) begin
								num_d   = b - CH_ZERO;
								phase_d = 2'd1;
							end else begin
								phase_d = 2'd2;
							end
						end
					end
					2'd1: begin
						if (is_digit) begin
							num_d = num_x10 + (b - CH_ZERO);
						end else begin
							phase_d = 2'd2;
						end
					end
					default: ;
				endcase
			end
			if (len_q <= LEN_MAX) begin
				len_d = len_q + LEN_W'(1);
			end
			if (last) begin
				res.status = ST_UNTERM;
			end
		end
		if (last) begin
			emit     = 1'b1;
			inside_d = 1'b0;
			len_d    = '0;
			num_d    = '0;
			phase_d  = 2'd0;
			neg_d    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			len_q    <= '0;
			num_q    <= '0;
			phase_q  <= 2'd0;
			neg_q    <= 1'b0;
		end else if (in_acc) begin
			inside_q <= inside_d;
			len_q    <= len_d;
			num_q    <= num_d;
			phase_q  <= phase_d;
			neg_q    <= neg_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && inside_q && b != CH_SEMI && len_q < LEN_W'(CMP_LEN)) begin
			name_q[len_q[$clog2(CMP_LEN)-1:0]] <= b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ch.ready) begin
			out_valid_q <= in_acc && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && emit) begin
			out_q <= res;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |=> out_valid_q && $stable(out_q))
		else $error("result changed while stalled");

	a_last_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && last |=> !inside_q && len_q == '0 && phase_q == 2'd0)
		else $error("state not cleared after last word");

	a_valid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.byte_valid |-> out_q.status == ST_OK)
		else $error("decoded byte with error status");

	a_unterm_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status == ST_UNTERM |-> out_q.end_of_text)
		else $error("unterminated status without end of text");

endmodule
`default_nettype wire
